FILE: rtl/clcf_pkg.sv
// Shared constants for the configuration line comment filter.
package clcf_pkg;

  // Line store depth; the store keeps at most LINE_MAX - 1 text bytes of one line.
  localparam int LINE_MAX     = 64;
  localparam int IDX_W        = $clog2(LINE_MAX);
  localparam int BUFFER_BYTES = 4096;
  localparam int ROOM_W       = 13;
  localparam int OFFSET_W     = 12;
  localparam int OUT_DATA_W   = 40;

  // Register indexes on the configuration port
  localparam logic REG_OUTPUT_ROOM = 1'b0;

  // Input kinds carried in tuser
  localparam logic ACT_TEXT = 1'b0;
  localparam logic ACT_EOF  = 1'b1;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;

endpackage

FILE: rtl/config_line_comment_filter.sv
// Configuration line comment filter: line store, judge and output sequencer.
//
// Channel   Dir  Payload
// s_*       in   tuser: action; tdata: text_byte
// m_*       out  tuser: byte_valid; tdata: out_byte, out_offset, overflow_seen,
//                long_line_seen, bytes_used; tlast: last_of_run
// APB       in   output_room at byte address 0
//
// A text byte is taken and, while the line store has room, written straight into it.
// A kept line drains byte by byte: each byte passes through a synchronous read
// of the line store (ST_READ) and then a load of the output register (ST_LOAD);
// the closing newline then comes from ST_NL. A status transfer comes from ST_STATUS.
// No input is taken while a line drains. Output stalls hold the sequencer.
// Reset is synchronous; the line store needs no clearing pass.
module config_line_comment_filter (
  input  logic                            clk,
  input  logic                            rst,
  // stream input
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // [7:0] text_byte
  input  logic                            s_tuser,  // [0] action
  // stream output
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] out_byte, [19:8] out_offset, [20] overflow_seen, [21] long_line_seen,
  // [34:22] bytes_used, [39:35] zero
  output logic [clcf_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tuser,  // [0] byte_valid
  output logic                            m_tlast,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_NL     = 3'd3;
  localparam logic [2:0] ST_STATUS = 3'd4;

  localparam int IW = clcf_pkg::IDX_W;
  localparam int RW = clcf_pkg::ROOM_W;

  logic [2:0]    state;
  logic [7:0]    line_store [clcf_pkg::LINE_MAX];
  logic [7:0]    rd_data;
  logic [IW-1:0] line_length;
  logic [IW-1:0] first_pos;
  logic          seen_text;
  logic          first_comment;
  logic [IW-1:0] rd_ptr;
  logic [IW-1:0] last_idx;
  logic          eof_pending;
  logic [RW-1:0] used_count;
  logic          overflow_flag;
  logic          long_flag;
  logic [RW-1:0] output_room;

  logic          in_xfer;
  logic          is_text;
  logic          is_blank;
  logic          store_we;
  logic          keep;
  logic          fit;
  logic [IW-1:0] line_n;
  logic          out_free;
  logic          out_load;
  logic          cfg_write;
  logic [RW-1:0] room_wr;

  // Output register payload
  logic          o_valid_byte;
  logic [7:0]    o_byte;
  logic [clcf_pkg::OFFSET_W-1:0] o_offset;
  logic          o_last;
  logic          o_over;
  logic          o_long;
  logic [RW-1:0] o_used;

  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign is_text  = (s_tuser == clcf_pkg::ACT_TEXT) && (s_tdata != clcf_pkg::CH_NL);
  assign is_blank = (s_tdata == clcf_pkg::CH_SPACE) || (s_tdata == clcf_pkg::CH_TAB) ||
                    (s_tdata == clcf_pkg::CH_CR);
  assign store_we = in_xfer && is_text && (line_length < IW'(clcf_pkg::LINE_MAX - 1));

  // Judge the line held so far: keep it unless blank or a comment, emit only if it fits
  assign keep   = seen_text && !first_comment;
  assign line_n = line_length - first_pos;
  assign fit    = ({1'b0, used_count} + (RW+1)'(line_n) + (RW+1)'(1)) <= {1'b0, output_room};

  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free &&
                    ((state == ST_LOAD) || (state == ST_NL) || (state == ST_STATUS));

  // Configuration port: writes land on the access phase, values above the buffer clamp
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == clcf_pkg::REG_OUTPUT_ROOM);
  assign room_wr   = (pwdata[RW-1:0] > RW'(clcf_pkg::BUFFER_BYTES)) ?
                     RW'(clcf_pkg::BUFFER_BYTES) : pwdata[RW-1:0];
  assign prdata    = {{(32-RW){1'b0}}, output_room};

  // Line store: one write port for incoming text, one registered read port for draining
  always_ff @(posedge clk) begin
    if (store_we) begin
      line_store[line_length] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rd_data <= line_store[rd_ptr];
    end
  end

  // Select what the output register takes this cycle
  always_comb begin
    o_valid_byte = 1'b1;
    o_byte       = rd_data;
    o_offset     = used_count[clcf_pkg::OFFSET_W-1:0];
    o_last       = 1'b0;
    o_over       = overflow_flag;
    o_long       = long_flag;
    o_used       = used_count + RW'(1);
    unique case (state)
      ST_NL: begin
        o_byte = clcf_pkg::CH_NL;
        o_last = 1'b1;
      end
      ST_STATUS: begin
        o_valid_byte = 1'b0;
        o_byte       = 8'd0;
        o_offset     = '0;
        o_last       = 1'b1;
        o_used       = used_count;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= o_valid_byte;
      m_tlast <= o_last;
      m_tdata <= {{(clcf_pkg::OUT_DATA_W - 35){1'b0}}, o_used, o_long, o_over, o_offset, o_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= out_load || (m_tvalid && !m_tready);
    end
  end

  // Main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      line_length   <= '0;
      first_pos     <= '0;
      seen_text     <= 1'b0;
      first_comment <= 1'b0;
      eof_pending   <= 1'b0;
      used_count    <= '0;
      overflow_flag <= 1'b0;
      long_flag     <= 1'b0;
      output_room   <= RW'(clcf_pkg::BUFFER_BYTES);
    end else begin
      if (cfg_write) begin
        output_room <= room_wr;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (is_text) begin
              if (store_we) begin
                line_length <= line_length + IW'(1);
                // Remember where text starts and whether it opens a comment
                if (!seen_text && !is_blank) begin
                  seen_text     <= 1'b1;
                  first_pos     <= line_length;
                  first_comment <= (s_tdata == clcf_pkg::CH_SEMI) ||
                                   (s_tdata == clcf_pkg::CH_HASH);
                end
              end else begin
                long_flag <= 1'b1;
              end
            end else begin
              // Newline or end of file: judge, then start the next line afresh
              eof_pending   <= s_tuser;
              line_length   <= '0;
              first_pos     <= '0;
              seen_text     <= 1'b0;
              first_comment <= 1'b0;
              if (keep && fit) begin
                rd_ptr   <= first_pos;
                last_idx <= line_length - IW'(1);
                state    <= ST_READ;
              end else begin
                if (keep) begin
                  overflow_flag <= 1'b1;
                end
                if (s_tuser == clcf_pkg::ACT_EOF) begin
                  state <= ST_STATUS;
                end
              end
            end
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            used_count <= used_count + RW'(1);
            if (rd_ptr == last_idx) begin
              state <= ST_NL;
            end else begin
              rd_ptr <= rd_ptr + IW'(1);
              state  <= ST_READ;
            end
          end
        end
        ST_NL: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (eof_pending) begin
              used_count    <= '0;
              overflow_flag <= 1'b0;
              long_flag     <= 1'b0;
            end else begin
              used_count <= used_count + RW'(1);
            end
          end
        end
        ST_STATUS: begin
          if (out_free) begin
            used_count    <= '0;
            overflow_flag <= 1'b0;
            long_flag     <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Draining never runs past the end of the stored line
  a_ptr_in_line: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (rd_ptr <= last_idx))
    else $error("read pointer past end of line");

  // A status transfer without a byte always closes its run
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("status transfer without tlast");

  // A plain text byte leaves the sequencer idle
  a_text_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == clcf_pkg::ACT_TEXT) && (s_tdata != clcf_pkg::CH_NL))
    |=> (state == ST_IDLE))
    else $error("text byte started an output run");

  // End of file leaves no used bytes behind once the run is delivered
  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    (out_load && o_last && eof_pending && (state == ST_NL)) |=> (used_count == '0))
    else $error("used count not cleared at end of file");
`endif

endmodule

FILE: dv/clcf_filter_checker.sv
// Checker for the line comment filter: predicts the filtered byte stream and compares it.
`timescale 1ns / 100ps

module clcf_filter_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [7:0]                      s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [clcf_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            m_tuser,
  input  logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  input  logic                            pready,
  output int                              mismatches,
  output int                              outstanding,
  output int                              results_seen
);

  localparam int IDX_BITS = clcf_pkg::IDX_W;

  typedef struct packed {
    logic                          byte_valid;
    logic [7:0]                    out_byte;
    logic [clcf_pkg::OFFSET_W-1:0] out_offset;
    logic                          last_of_run;
    logic                          overflow_seen;
    logic                          long_line_seen;
    logic [clcf_pkg::ROOM_W-1:0]   bytes_used;
  } filt_out_t;

  localparam logic [2:0] ROOM_ADDR = {clcf_pkg::REG_OUTPUT_ROOM, 2'b00};
  localparam int         PAD_LSB   = 22 + clcf_pkg::ROOM_W;

  // Shadow of the filter state
  logic [7:0] line_buf [clcf_pkg::LINE_MAX];
  int         shadow_len;
  int         text_start;
  logic       text_seen;
  int         used_bytes;
  int         room_cap;
  logic       ovf_sticky;
  logic       long_sticky;

  filt_out_t  filtered_q [$];

  task automatic push_out(input logic vld, input logic [7:0] b, input int off,
                          input int used_after);
    filt_out_t rec;
    rec.byte_valid     = vld;
    rec.out_byte       = b;
    rec.out_offset     = off[clcf_pkg::OFFSET_W-1:0];
    rec.last_of_run    = 1'b0;
    rec.overflow_seen  = ovf_sticky;
    rec.long_line_seen = long_sticky;
    rec.bytes_used     = used_after[clcf_pkg::ROOM_W-1:0];
    filtered_q.push_back(rec);
  endtask

  task automatic mark_last();
    filt_out_t rec;
    rec = filtered_q.pop_back();
    rec.last_of_run = 1'b1;
    filtered_q.push_back(rec);
  endtask

  // Judge the collected line: emit a kept line with a closing newline if it fits, else flag overflow.
  task automatic close_line(output int n_pushed);
    int n;
    n_pushed = 0;
    if (text_seen && text_start < shadow_len &&
        line_buf[IDX_BITS'(text_start)] != clcf_pkg::CH_SEMI &&
        line_buf[IDX_BITS'(text_start)] != clcf_pkg::CH_HASH) begin
      n = shadow_len - text_start;
      if (used_bytes + n + 1 <= room_cap) begin
        for (int i = 0; i < n; i++) begin
          push_out(1'b1, line_buf[IDX_BITS'(text_start + i)], used_bytes, used_bytes + 1);
          used_bytes++;
        end
        push_out(1'b1, clcf_pkg::CH_NL, used_bytes, used_bytes + 1);
        used_bytes++;
        n_pushed = n + 1;
      end else begin
        ovf_sticky = 1'b1;
      end
    end
    shadow_len = 0;
    text_start = 0;
    text_seen  = 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    int        n;
    filt_out_t want;
    if (rst) begin
      shadow_len   = 0;
      text_start   = 0;
      text_seen    = 1'b0;
      used_bytes   = 0;
      room_cap     = clcf_pkg::BUFFER_BYTES;
      ovf_sticky   = 1'b0;
      long_sticky  = 1'b0;
      mismatches   = 0;
      results_seen = 0;
      filtered_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ROOM_ADDR)
        room_cap = (pwdata[clcf_pkg::ROOM_W-1:0] > clcf_pkg::BUFFER_BYTES) ?
                   clcf_pkg::BUFFER_BYTES : int'(pwdata[clcf_pkg::ROOM_W-1:0]);

      if (m_tvalid && m_tready) begin
        results_seen++;
        if (filtered_q.size() == 0) begin
          $error("output transfer with nothing expected: tdata %h", m_tdata);
          mismatches++;
        end else begin
          want = filtered_q.pop_front();
          check_field("byte_valid", int'(want.byte_valid), int'(m_tuser));
          check_field("out_byte", int'(want.out_byte), int'(m_tdata[7:0]));
          check_field("out_offset", int'(want.out_offset), int'(m_tdata[19:8]));
          check_field("overflow_seen", int'(want.overflow_seen), int'(m_tdata[20]));
          check_field("long_line_seen", int'(want.long_line_seen), int'(m_tdata[21]));
          check_field("bytes_used", int'(want.bytes_used), int'(m_tdata[34:22]));
          check_field("tdata padding", 0, int'(m_tdata[clcf_pkg::OUT_DATA_W-1:PAD_LSB]));
          check_field("last_of_run", int'(want.last_of_run), int'(m_tlast));
        end
      end

      if (s_tvalid && s_tready) begin
        if (s_tuser == clcf_pkg::ACT_TEXT) begin
          if (s_tdata == clcf_pkg::CH_NL) begin
            close_line(n);
            if (n > 0) mark_last();
          end else if (shadow_len + 1 < clcf_pkg::LINE_MAX) begin
            line_buf[IDX_BITS'(shadow_len)] = s_tdata;
            if (!text_seen && s_tdata != clcf_pkg::CH_SPACE &&
                s_tdata != clcf_pkg::CH_TAB && s_tdata != clcf_pkg::CH_CR) begin
              text_seen  = 1'b1;
              text_start = shadow_len;
            end
            shadow_len++;
          end else begin
            long_sticky = 1'b1;
          end
        end else begin
          close_line(n);
          if (n == 0) push_out(1'b0, 8'h00, 0, used_bytes);
          mark_last();
          used_bytes  = 0;
          ovf_sticky  = 1'b0;
          long_sticky = 1'b0;
        end
      end
    end
    outstanding <= filtered_q.size();
  end

endmodule

FILE: dv/config_line_comment_filter_tb.sv
// Testbench top for the line comment filter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module config_line_comment_filter_tb;

  localparam int          ROOM_BITS   = clcf_pkg::ROOM_W;
  localparam int          ITEM_TARGET = 400;      // random input transfers to aim for
  localparam int unsigned CYCLE_LIMIT = 400_000;  // many times the slowest correct run
  localparam int          DRAIN_TAIL  = 16;       // quiet cycles after the last result
  localparam int          HOLD_CYCLES = 400;      // long receiver hold-off
  localparam int          TX_CALM_LO  = 150;      // sender never idles between these items
  localparam int          TX_CALM_HI  = 260;
  localparam int unsigned RX_CALM_LO  = 1200;     // receiver never stalls between these cycles
  localparam int unsigned RX_CALM_HI  = 2200;
  localparam logic [2:0]  ROOM_ADDR   = {clcf_pkg::REG_OUTPUT_ROOM, 2'b00};

  logic                            clk;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [7:0]                      s_tdata  = 8'h00;
  logic                            s_tuser  = clcf_pkg::ACT_TEXT;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [clcf_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            m_tuser;
  logic                            m_tlast;
  logic                            psel     = 1'b0;
  logic                            penable  = 1'b0;
  logic                            pwrite   = 1'b0;
  logic [2:0]                      paddr    = 3'd0;
  logic [31:0]                     pwdata   = 32'd0;
  logic [31:0]                     prdata;
  logic                            pready;

  int                              mismatches;
  int                              outstanding;
  int                              results_seen;

  int                              items_sent  = 0;
  int                              files_done  = 0;
  int                              room_writes = 0;
  int unsigned                     cycle_count = 0;

  // Receiver hold-off control: the stimulus raises the request, the receiver owns the count
  logic                            want_hold   = 1'b0;
  logic                            hold_done   = 1'b0;
  int                              hold_left   = 0;
  int unsigned                     rx_cycle    = 0;

  config_line_comment_filter dut (.*);

  clcf_filter_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Give up if the run hangs; nothing else ends the run early
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Cycle limit hit with %0d results still expected", outstanding);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: stall at random about 8 percent of the time, never in the calm window, and
  // hold off once for a long stretch when the stimulus asks for it.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (want_hold && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (rx_cycle >= RX_CALM_LO && rx_cycle < RX_CALM_HI) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 8);
    end
  end

  // Write output_room through a setup and an access phase
  task automatic write_room(input logic [ROOM_BITS-1:0] room);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROOM_ADDR;
    pwdata  <= {{(32-ROOM_BITS){1'b0}}, room};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    room_writes++;
  endtask

  // Offer one transfer, with an occasional idle gap first, and hold it until accepted.
  // Valid stays high between back-to-back transfers.
  task automatic send_item(input logic act, input logic [7:0] b);
    if (items_sent < TX_CALM_LO || items_sent >= TX_CALM_HI) begin
      while ($urandom_range(99) < 8) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Drop valid, wait until every expected result has come, then let the block settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Any byte except newline
  function automatic logic [7:0] any_text_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == clcf_pkg::CH_NL);
    return c;
  endfunction

  // A byte that starts a line which is kept: not blank, not a comment mark, not newline
  function automatic logic [7:0] lead_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == clcf_pkg::CH_NL || c == clcf_pkg::CH_SPACE || c == clcf_pkg::CH_TAB ||
           c == clcf_pkg::CH_CR || c == clcf_pkg::CH_SEMI || c == clcf_pkg::CH_HASH);
    return c;
  endfunction

  // Text of a kept line without its newline
  task automatic send_line_body(input int len);
    send_item(clcf_pkg::ACT_TEXT, lead_byte());
    for (int i = 1; i < len; i++) send_item(clcf_pkg::ACT_TEXT, any_text_byte());
  endtask

  // One line of a random file: mostly well formed, sometimes raw noise
  task automatic send_random_line();
    int kind;
    int lead;
    int len;
    kind = int'($urandom_range(99));
    lead = ($urandom_range(3) == 0) ? int'($urandom_range(1, 4)) : 0;
    for (int i = 0; i < lead; i++) begin
      case ($urandom_range(2))
        0:       send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_SPACE);
        1:       send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_TAB);
        default: send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_CR);
      endcase
    end
    if (kind < 55) begin
      // kept line; now and then one longer than the line store
      len = ($urandom_range(11) == 0) ? int'($urandom_range(50, 75))
                                      : int'($urandom_range(1, 10));
      send_line_body(len);
    end else if (kind < 70) begin
      send_item(clcf_pkg::ACT_TEXT,
                ($urandom_range(1) == 0) ? clcf_pkg::CH_SEMI : clcf_pkg::CH_HASH);
      len = int'($urandom_range(0, 6));
      for (int i = 0; i < len; i++) send_item(clcf_pkg::ACT_TEXT, any_text_byte());
    end else if (kind < 82) begin
      // blank line: the leading blanks above, if any, then the newline
    end else begin
      // noise: fully random bytes, newlines included
      len = int'($urandom_range(0, 8));
      for (int i = 0; i < len; i++) send_item(clcf_pkg::ACT_TEXT, 8'($urandom_range(255)));
    end
    send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_NL);
  endtask

  initial begin : stimulus
    int                   random_base;
    int                   lines;
    logic [ROOM_BITS-1:0] room;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed file under the reset room: leading blanks, a kept line with
    // carriage return and 0xFF inside, hash and semicolon comments, a blank line,
    // then a line closed by end of file with the newline doubling as status.
    send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_SPACE);
    send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_TAB);
    send_item(clcf_pkg::ACT_TEXT, 8'h41);
    send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_CR);
    send_item(clcf_pkg::ACT_TEXT, 8'hFF);
    send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_NL);
    send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_HASH);
    send_item(clcf_pkg::ACT_TEXT, 8'h63);
    send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_NL);
    send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_SEMI);
    send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_NL);
    send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_SPACE);
    send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_NL);
    send_item(clcf_pkg::ACT_TEXT, 8'h00);
    send_item(clcf_pkg::ACT_EOF, 8'hFF);
    // End of file with nothing pending: bare status transfer
    send_item(clcf_pkg::ACT_EOF, 8'h00);
    wait_drained();

    // Tiny room: a line that exactly fits, then one that overflows
    write_room(13'd3);
    send_item(clcf_pkg::ACT_TEXT, 8'h61);
    send_item(clcf_pkg::ACT_TEXT, 8'h62);
    send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_NL);
    send_item(clcf_pkg::ACT_TEXT, 8'h61);
    send_item(clcf_pkg::ACT_TEXT, 8'h62);
    send_item(clcf_pkg::ACT_TEXT, 8'h63);
    send_item(clcf_pkg::ACT_TEXT, 8'h64);
    send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_NL);
    send_item(clcf_pkg::ACT_EOF, 8'h5A);
    wait_drained();

    // Room above the buffer size is clamped
    write_room(13'h1FFF);

    // Long receiver hold-off while the sender keeps offering kept lines,
    // so the block fills up and stalls its input
    want_hold <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      send_line_body(8);
      send_item(clcf_pkg::ACT_TEXT, clcf_pkg::CH_NL);
    end
    send_item(clcf_pkg::ACT_EOF, 8'($urandom_range(255)));
    wait_drained();
    files_done = 3;

    // Random files, each under a fresh room setting; pause for all results between files
    random_base = items_sent;
    while (items_sent - random_base < ITEM_TARGET) begin
      case (files_done)
        3:       room = 13'd0;
        4:       room = ROOM_BITS'(clcf_pkg::BUFFER_BYTES);
        default: begin
          case ($urandom_range(5))
            0:       room = 13'd0;
            1:       room = ROOM_BITS'(clcf_pkg::BUFFER_BYTES);
            2:       room = 13'h1FFF;
            3, 4:    room = ROOM_BITS'($urandom_range(0, 40));
            default: room = ROOM_BITS'($urandom_range(0, 8191));
          endcase
        end
      endcase
      write_room(room);
      lines = int'($urandom_range(1, 6));
      repeat (lines) send_random_line();
      // sometimes leave a line open for end of file to close
      if ($urandom_range(2) == 0) send_line_body(int'($urandom_range(1, 5)));
      send_item(clcf_pkg::ACT_EOF, 8'($urandom_range(255)));
      wait_drained();
      files_done++;
    end

    $display("Run covered %0d input transfers in %0d files under %0d room settings,",
             items_sent, files_done, room_writes);
    $display("with %0d output transfers checked across overflow, long lines and stalls.",
             results_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/clcf_pkg.sv
rtl/config_line_comment_filter.sv
dv/clcf_filter_checker.sv
dv/config_line_comment_filter_tb.sv
